// ===== design/r4dc_pkg.sv =====
package r4dc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIM2      = 9;
  localparam int ENTRIES   = 81;
  localparam int ROW_W     = 4;
  localparam int IDX_W     = 7;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 64;
  localparam int SUM_W     = 68;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_APPLY = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_t;

  typedef struct packed {
    logic                    action;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] a_00;
    logic signed [VAL_W-1:0] a_01;
    logic signed [VAL_W-1:0] a_02;
    logic signed [VAL_W-1:0] a_10;
    logic signed [VAL_W-1:0] a_11;
    logic signed [VAL_W-1:0] a_12;
    logic signed [VAL_W-1:0] a_20;
    logic signed [VAL_W-1:0] a_21;
    logic signed [VAL_W-1:0] a_22;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_00;
    logic signed [VAL_W-1:0] out_01;
    logic signed [VAL_W-1:0] out_02;
    logic signed [VAL_W-1:0] out_10;
    logic signed [VAL_W-1:0] out_11;
    logic signed [VAL_W-1:0] out_12;
    logic signed [VAL_W-1:0] out_20;
    logic signed [VAL_W-1:0] out_21;
    logic signed [VAL_W-1:0] out_22;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic                    vld;
    logic [ROW_W-1:0]        row;
    logic                    sum_vld;
    logic signed [SUM_W-1:0] sum;
  } link_t;

  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] val;
    logic                    clamp;
  } sres_t;

  typedef struct packed {
    logic             ok;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } idx_split_t;

  function automatic idx_split_t split_index(input logic [IDX_W-1:0] idx);
    idx_split_t       s;
    logic [12:0]      q;
    logic [IDX_W-1:0] base;
    q     = {6'd0, idx} * 13'd57;
    s.row = q[12:9];
    base  = IDX_W'({3'd0, s.row}) * IDX_W'(DIM2);
    s.col = ROW_W'(idx - base);
    s.ok  = (idx < IDX_W'(ENTRIES));
    return s;
  endfunction

endpackage

// ===== design/r4dc_ram.sv =====
module r4dc_ram #(
  parameter int Width = 32,
  parameter int Depth = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/r4dc_cell.sv =====
module r4dc_cell
  import r4dc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    a_ld,
  input  logic signed [VAL_W-1:0] a_val,
  input  logic                    wr_en,
  input  logic [ROW_W-1:0]        wr_addr,
  input  logic signed [VAL_W-1:0] wr_data,
  input  link_t                   link_in,
  output link_t                   link_out
);

  logic                     vld_r;
  logic [ROW_W-1:0]         row_r;
  logic                     hit_r;
  logic                     vld2_r;
  logic                     sum_vld_r;
  logic [DIM2-1:0]          vbits_r;
  logic signed [VAL_W-1:0]  a_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [VAL_W-1:0]         rdata;
  logic signed [VAL_W-1:0]  entry;

  r4dc_ram #(
    .Width(VAL_W),
    .Depth(DIM2)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(link_in.row),
    .rdata(rdata)
  );

  assign entry = hit_r ? $signed(rdata) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      vld2_r    <= 1'b0;
      sum_vld_r <= 1'b0;
      vbits_r   <= '0;
    end else begin
      vld_r     <= link_in.vld;
      vld2_r    <= vld_r;
      sum_vld_r <= vld2_r;
      if (wr_en) begin
        vbits_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ld) begin
      a_r <= a_val;
    end
    row_r  <= link_in.row;
    hit_r  <= vbits_r[link_in.row];
    prod_r <= entry * a_r;
    sum_r  <= {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} + link_in.sum;
  end

  assign link_out = '{vld: vld_r, row: row_r, sum_vld: sum_vld_r, sum: sum_r};

endmodule

// ===== design/r4dc_round.sv =====
module r4dc_round
  import r4dc_pkg::*;
#(
  parameter int FracBits = FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    sum_vld,
  input  logic signed [SUM_W-1:0] sum,
  output sres_t                   res
);

  localparam logic signed [SUM_W-1:0] HALF = (SUM_W'(1) << FracBits) >> 1;
  localparam logic signed [SUM_W-1:0] MAXV = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SUM_W-1:0] MINV = {{(SUM_W-31){1'b1}}, 31'd0};

  logic signed [SUM_W-1:0] biased;
  logic signed [SUM_W-1:0] rnd;
  logic signed [VAL_W-1:0] val_nxt;
  logic                    clamp_nxt;
  logic                    vld_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    clamp_r;

  always_comb begin
    biased = sum + HALF;
    rnd    = biased >>> FracBits;
    if (rnd > MAXV) begin
      val_nxt   = {1'b0, {(VAL_W-1){1'b1}}};
      clamp_nxt = 1'b1;
    end else if (rnd < MINV) begin
      val_nxt   = {1'b1, {(VAL_W-1){1'b0}}};
      clamp_nxt = 1'b1;
    end else begin
      val_nxt   = rnd[VAL_W-1:0];
      clamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    clamp_r <= clamp_nxt;
  end

  assign res = '{vld: vld_r, val: val_r, clamp: clamp_r};

endmodule

// ===== design/rank4_rank2_double_contraction.sv =====
// Double contraction of a stored 3x3x3x3 fixed-point tensor with a 3x3 tensor.
// A load item (action 0) writes one entry at flat index i*27+j*9+k*3+l;
// busy stays low and no result follows. An index above 80 is dropped. The
// store reads as zero after reset with no clearing pass. An apply item
// (action 1) raises busy until its result is shown on out_data with
// out_strobe high for exactly one cycle; busy is low again in that cycle, so
// the next item may be started then. The receiver cannot stall the result:
// sample it when out_strobe is high. The result passes through the row of
// nine multiply-accumulate cells, each a RAM read, multiply and add stage,
// through which the nine output rows stream one per cycle, followed by one
// rounding stage. Results are rounded half up to FracBits fraction bits and
// saturated to 32 bits; saturated flags any clamped element.
module rank4_rank2_double_contraction
  import r4dc_pkg::*;
#(
  parameter int FracBits = FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data
);

  st_t                     state_r;
  st_t                     state_nxt;
  logic                    acc;
  logic                    apply_acc;
  logic                    load_acc;
  logic                    done;
  idx_split_t              wsel;
  logic                    issue_act_r;
  logic [ROW_W-1:0]        issue_row_r;
  logic [ROW_W-1:0]        col_cnt_r;
  logic                    out_strobe_r;
  logic signed [VAL_W-1:0] res_r [DIM2];
  logic                    sat_acc_r;
  logic signed [VAL_W-1:0] a_in [DIM2];
  link_t                   lk [DIM2+1];
  sres_t                   rd;

  assign acc       = start && !busy;
  assign apply_acc = acc && (in_data.action == ACT_APPLY);
  assign load_acc  = acc && (in_data.action == ACT_LOAD);
  assign wsel      = split_index(in_data.entry_index);
  assign done      = rd.vld && (col_cnt_r == ROW_W'(DIM2-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (apply_acc) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        busy = 1'b1;
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_act_r <= 1'b0;
      issue_row_r <= '0;
    end else if (apply_acc) begin
      issue_act_r <= 1'b1;
      issue_row_r <= '0;
    end else if (issue_act_r) begin
      if (issue_row_r == ROW_W'(DIM2-1)) begin
        issue_act_r <= 1'b0;
      end
      issue_row_r <= issue_row_r + 1'b1;
    end
  end

  assign a_in[0] = in_data.a_00;
  assign a_in[1] = in_data.a_01;
  assign a_in[2] = in_data.a_02;
  assign a_in[3] = in_data.a_10;
  assign a_in[4] = in_data.a_11;
  assign a_in[5] = in_data.a_12;
  assign a_in[6] = in_data.a_20;
  assign a_in[7] = in_data.a_21;
  assign a_in[8] = in_data.a_22;

  assign lk[0] = '{vld: issue_act_r, row: issue_row_r, sum_vld: 1'b0, sum: '0};

  for (genvar c = 0; c < DIM2; c++) begin : g_cell
    r4dc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .a_ld    (apply_acc),
      .a_val   (a_in[c]),
      .wr_en   (load_acc && wsel.ok && (wsel.col == ROW_W'(c))),
      .wr_addr (wsel.row),
      .wr_data (in_data.entry_value),
      .link_in (lk[c]),
      .link_out(lk[c+1])
    );
  end

  r4dc_round #(
    .FracBits(FracBits)
  ) u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .sum_vld(lk[DIM2].sum_vld),
    .sum    (lk[DIM2].sum),
    .res    (rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= done;
      if (rd.vld) begin
        col_cnt_r <= done ? '0 : col_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.vld) begin
      res_r[DIM2-1] <= rd.val;
      for (int k = 0; k < DIM2-1; k++) begin
        res_r[k] <= res_r[k+1];
      end
      sat_acc_r <= (col_cnt_r == '0) ? rd.clamp : (sat_acc_r | rd.clamp);
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_data.out_00    = res_r[0];
  assign out_data.out_01    = res_r[1];
  assign out_data.out_02    = res_r[2];
  assign out_data.out_10    = res_r[3];
  assign out_data.out_11    = res_r[4];
  assign out_data.out_12    = res_r[5];
  assign out_data.out_20    = res_r[6];
  assign out_data.out_21    = res_r[7];
  assign out_data.out_22    = res_r[8];
  assign out_data.saturated = sat_acc_r;

`ifndef ASSERT_OFF
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a preceding apply");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> !busy)
    else $error("load item raised busy");

  a_apply_busy: assert property (@(posedge clk) disable iff (!rst_n)
    apply_acc |=> busy && issue_act_r && (issue_row_r == '0))
    else $error("apply item did not start the cell row");
`endif

endmodule

// ===== tb/rank4_rank2_double_contraction_test.sv =====
module rank4_rank2_double_contraction_test;
  timeunit 1ns;
  timeprecision 1ps;

  import r4dc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 30;

  class tensor_scoreboard;
    logic signed [VAL_W-1:0] tensor_store[ENTRIES];
    out_item_t               pending[$];
    int                      errors;

    function new();
      foreach (tensor_store[n]) tensor_store[n] = '0;
      errors = 0;
    endfunction

    function out_item_t contract(in_item_t it);
      logic signed [VAL_W-1:0] a[DIM2];
      logic signed [VAL_W-1:0] v[DIM2];
      logic signed [63:0]      prod;
      logic signed [67:0]      acc;
      logic signed [67:0]      rnd;
      logic                    sat;
      out_item_t               r;
      a = '{it.a_00, it.a_01, it.a_02, it.a_10, it.a_11, it.a_12, it.a_20, it.a_21, it.a_22};
      sat = 1'b0;
      for (int ij = 0; ij < DIM2; ij++) begin
        acc = '0;
        for (int kl = 0; kl < DIM2; kl++) begin
          prod = tensor_store[ij*DIM2+kl] * a[kl];
          acc  = acc + prod;
        end
        if (FRAC_BITS > 0) begin
          acc = acc + (68'sd1 <<< (FRAC_BITS - 1));
        end
        rnd = acc >>> FRAC_BITS;
        if (rnd > 68'sd2147483647) begin
          v[ij] = 32'sh7FFFFFFF;
          sat   = 1'b1;
        end else if (rnd < -68'sd2147483648) begin
          v[ij] = 32'sh80000000;
          sat   = 1'b1;
        end else begin
          v[ij] = rnd[31:0];
        end
      end
      r = '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], sat};
      return r;
    endfunction

    function void note_item(in_item_t it);
      if (it.action == ACT_LOAD) begin
        if (it.entry_index < IDX_W'(ENTRIES)) tensor_store[it.entry_index] = it.entry_value;
      end else begin
        pending = {pending, contract(it)};
      end
    endfunction

    task report_mismatch(string what, logic signed [VAL_W-1:0] got_v,
                         logic signed [VAL_W-1:0] want_v);
      $display("mismatch %s: got %0d, want %0d", what, got_v, want_v);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t               want;
      logic signed [VAL_W-1:0] g[DIM2];
      logic signed [VAL_W-1:0] w[DIM2];
      string                   names[DIM2];
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got.out_00, '0);
      end else begin
        want = pending.pop_front();
        names = '{"out_00", "out_01", "out_02", "out_10", "out_11", "out_12",
                  "out_20", "out_21", "out_22"};
        g = '{got.out_00, got.out_01, got.out_02, got.out_10, got.out_11, got.out_12,
              got.out_20, got.out_21, got.out_22};
        w = '{want.out_00, want.out_01, want.out_02, want.out_10, want.out_11,
              want.out_12, want.out_20, want.out_21, want.out_22};
        for (int n = 0; n < DIM2; n++) begin
          if (g[n] !== w[n]) report_mismatch(names[n], g[n], w[n]);
        end
        if (got.saturated !== want.saturated) begin
          report_mismatch("saturated", VAL_W'(got.saturated), VAL_W'(want.saturated));
        end
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_strobe;
  out_item_t out_data;

  tensor_scoreboard sb = new();
  int               cycle_count = 0;

  rank4_rank2_double_contraction i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_data);
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned kind;
    logic signed [VAL_W-1:0] v;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      7, 8:       v = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      default: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh7FFFFFFF;
          1:       v = 32'sh80000000;
          2:       v = 32'sd1;
          3:       v = -32'sd1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.action      = 1'($urandom);
    it.entry_index = IDX_W'($urandom);
    it.entry_value = $urandom;
    it.a_00 = $urandom;
    it.a_01 = $urandom;
    it.a_02 = $urandom;
    it.a_10 = $urandom;
    it.a_11 = $urandom;
    it.a_12 = $urandom;
    it.a_20 = $urandom;
    it.a_21 = $urandom;
    it.a_22 = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_load(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val);
    in_item_t it;
    it             = random_item();
    it.action      = ACT_LOAD;
    it.entry_index = idx;
    it.entry_value = val;
    return it;
  endfunction

  function automatic in_item_t make_apply(logic signed [VAL_W-1:0] a[DIM2]);
    in_item_t it;
    it        = random_item();
    it.action = ACT_APPLY;
    {it.a_00, it.a_01, it.a_02, it.a_10, it.a_11, it.a_12, it.a_20, it.a_21, it.a_22} =
      {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task pause(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= random_item();
    end
  endtask

  task send(in_item_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task send_apply_fill(logic signed [VAL_W-1:0] val);
    logic signed [VAL_W-1:0] a[DIM2];
    foreach (a[n]) a[n] = val;
    send(make_apply(a));
  endtask

  task send_apply_single(int unsigned pos, logic signed [VAL_W-1:0] val);
    logic signed [VAL_W-1:0] a[DIM2];
    foreach (a[n]) a[n] = '0;
    a[pos] = val;
    send(make_apply(a));
  endtask

  initial begin
    logic signed [VAL_W-1:0] a[DIM2];
    in_item_t                it;
    logic                    burst;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    a = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd1, -32'sd1, 32'sh12345678, 32'sh0,
          32'sh7FFFFFFF, 32'sh80000000, -32'sd65536};
    send(make_apply(a));
    send(make_load(7'd0, 32'sh80000000));
    send(make_load(7'd80, 32'sh7FFFFFFF));
    send(make_load(7'd81, 32'sh12345678));
    send(make_load(7'd127, -32'sd1));
    send_apply_fill(32'sh80000000);
    send_apply_fill(32'sh7FFFFFFF);
    send(make_load(7'd40, 32'sd1));
    send_apply_single(4, 32'sh8000);
    send_apply_single(4, -32'sh8000);
    send_apply_single(4, 32'sh7FFF);
    send_apply_single(4, -32'sh8001);
    send(make_load(7'd0, 32'sh10000));
    send_apply_single(0, 32'sh30000);
    send(make_load(7'd80, -32'sh28000));
    send_apply_single(8, 32'sh18000);
    send(make_load(7'd0, '0));
    send(make_load(7'd80, '0));
    pause(3);

    burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      if ($urandom_range(0, 99) < 55) begin
        it = make_load($urandom_range(0, 9) == 0 ? IDX_W'($urandom_range(81, 127))
                                                 : IDX_W'($urandom_range(0, 80)),
                       pick_value());
      end else begin
        foreach (a[k]) a[k] = pick_value();
        it = make_apply(a);
      end
      send(it);
      if (!burst) pause(pick_gap());
    end
    pause(1);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.report_mismatch("results still pending", VAL_W'(sb.pending.size()), '0);
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
